// ===== design/mwpm_pkg.sv =====
// mecanum wheel pwm mixer: shared types, constants and register codes
// used by every design file; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package mwpm_pkg;

   // median batch
   localparam int MEDIAN_WINDOW = 5;
   localparam int FILL_W        = $clog2(MEDIAN_WINDOW);
   localparam int RANK_W        = $clog2(MEDIAN_WINDOW);

   // field widths
   localparam int AXIS_IN_W  = 8;
   localparam int AXIS_W     = 11;
   localparam int SUM_W      = 13;
   localparam int COMPARE_W  = 9;
   localparam int DEAD_W     = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // axis map: (v - lo) * 127 / span - 127, truncated toward zero
   localparam int ABSENT_AXIS   = 50;
   localparam int JOY_LO        = 10;
   localparam int TILT_LO       = -90;
   localparam int JOY_SPAN      = 40;
   localparam int TILT_SPAN     = 90;
   localparam int AXIS_HALF     = 127;
   localparam int AXIS_SHIFT    = 16;
   localparam int AXIS_RECIP_W  = 18;
   localparam int JOY_RECIP     = (AXIS_HALF * (2 ** AXIS_SHIFT) + JOY_SPAN - 1) / JOY_SPAN;
   localparam int TILT_RECIP    = (AXIS_HALF * (2 ** AXIS_SHIFT) + TILT_SPAN - 1) / TILT_SPAN;

   // wheel map: (s + 127) * 499 / 127 - 499, truncated toward zero
   localparam int WHEEL_MAX     = 499;
   localparam int WHEEL_SHIFT   = 20;
   localparam int WHEEL_RECIP_W = 23;
   localparam int WHEEL_RECIP   =
      (WHEEL_MAX * (2 ** WHEEL_SHIFT) + AXIS_HALF - 1) / AXIS_HALF;
   localparam int PWM_TOP       = 500;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIXING_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND   = 1'd1;

   localparam logic [DEAD_W-1:0] DEAD_BAND_RESET = 9'd20;

   typedef enum logic [1:0] {
      MODE_RADIO_JOY  = 2'd0,
      MODE_APP_JOY    = 2'd1,
      MODE_RADIO_TILT = 2'd2,
      MODE_APP_TILT   = 2'd3
   } mode_type;

   typedef logic signed [AXIS_IN_W-1:0] sample_batch_type [MEDIAN_WINDOW];

   // load enables of the two wheel lane stages
   typedef struct packed {
      logic mul;
      logic fin;
   } wheel_en_type;

endpackage

`default_nettype wire

// ===== design/mwpm_median_batch.sv =====
// app tilt batch store and median network for pitch and roll
// depends on mwpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwpm_median_batch (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    wr_en,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   pitch_in,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   roll_in,
   output logic                                         last,
   output logic signed [mwpm_pkg::AXIS_IN_W-1:0]        pitch_med,
   output logic signed [mwpm_pkg::AXIS_IN_W-1:0]        roll_med
);

   mwpm_pkg::sample_batch_type            pitch_ff;
   mwpm_pkg::sample_batch_type            roll_ff;
   logic [mwpm_pkg::FILL_W-1:0]           fill_ff;
   logic [mwpm_pkg::FILL_W-1:0]           fill_in;

   // rank of each entry with ties broken by position; the median has the middle rank
   function automatic logic signed [mwpm_pkg::AXIS_IN_W-1:0] batch_median(
      input mwpm_pkg::sample_batch_type t
   );
      logic [mwpm_pkg::RANK_W-1:0]              rank;
      logic signed [mwpm_pkg::AXIS_IN_W-1:0]    res;
      res = '0;
      for (int i = 0; i < mwpm_pkg::MEDIAN_WINDOW; i++) begin
         rank = '0;
         for (int j = 0; j < mwpm_pkg::MEDIAN_WINDOW; j++) begin
            if ((t[j] < t[i]) || ((t[j] == t[i]) && (j < i))) begin
               rank = rank + mwpm_pkg::RANK_W'(1);
            end
         end
         if (rank == mwpm_pkg::RANK_W'(mwpm_pkg::MEDIAN_WINDOW / 2)) begin
            res = t[i];
         end
      end
      return res;
   endfunction

   assign last      = (fill_ff == mwpm_pkg::FILL_W'(mwpm_pkg::MEDIAN_WINDOW - 1));
   assign fill_in   = last ? '0 : fill_ff + mwpm_pkg::FILL_W'(1);
   assign pitch_med = batch_median(pitch_ff);
   assign roll_med  = batch_median(roll_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (wr_en) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pitch_ff[fill_ff] <= pitch_in;
         roll_ff[fill_ff]  <= roll_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mwpm_axis_lane.sv =====
// one axis lane: absent stick substitution and linear rescale to -127..127
// depends on mwpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwpm_axis_lane (
   input  wire logic                                    clock,
   input  wire logic                                    en,
   input  wire mwpm_pkg::mode_type                      mode,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   axis_in,
   input  wire logic                                    present,
   output logic signed [mwpm_pkg::AXIS_W-1:0]           mapped
);

   logic                                     joy;
   logic                                     tilt_app;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]    src;
   logic signed [9:0]                        offs;
   logic                                     neg;
   logic [7:0]                               mag;
   logic [mwpm_pkg::AXIS_RECIP_W-1:0]        recip;
   logic [mwpm_pkg::AXIS_RECIP_W+7:0]        prod;
   logic [8:0]                               quo;
   logic signed [mwpm_pkg::AXIS_W-1:0]       sq;
   logic signed [mwpm_pkg::AXIS_W-1:0]       mapped_in;
   logic signed [mwpm_pkg::AXIS_W-1:0]       mapped_ff;

   assign joy      = (mode == mwpm_pkg::MODE_RADIO_JOY) || (mode == mwpm_pkg::MODE_APP_JOY);
   assign tilt_app = (mode == mwpm_pkg::MODE_APP_TILT);
   assign src      = (joy && !present) ? mwpm_pkg::AXIS_IN_W'(mwpm_pkg::ABSENT_AXIS) : axis_in;
   assign offs     = tilt_app ? 10'(src) - 10'(mwpm_pkg::TILT_LO)
                              : 10'(src) - 10'(mwpm_pkg::JOY_LO);
   assign neg      = offs[9];
   assign mag      = 8'(neg ? -offs : offs);
   assign recip    = tilt_app ? mwpm_pkg::AXIS_RECIP_W'(mwpm_pkg::TILT_RECIP)
                              : mwpm_pkg::AXIS_RECIP_W'(mwpm_pkg::JOY_RECIP);
   assign prod     = (mwpm_pkg::AXIS_RECIP_W + 8)'(mag)
                   * (mwpm_pkg::AXIS_RECIP_W + 8)'(recip);
   assign quo      = prod[mwpm_pkg::AXIS_SHIFT+8:mwpm_pkg::AXIS_SHIFT];
   assign sq       = $signed({2'b00, quo});
   assign mapped_in = (neg ? -sq : sq) - mwpm_pkg::AXIS_W'(mwpm_pkg::AXIS_HALF);

   always_ff @(posedge clock) begin
      if (en) begin
         mapped_ff <= mapped_in;
      end
   end

   assign mapped = mapped_ff;

endmodule

`default_nettype wire

// ===== design/mwpm_wheel_lane.sv =====
// one wheel lane: rescale to -499..499, deadband, clamp, compare and direction
// depends on mwpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwpm_wheel_lane (
   input  wire logic                                 clock,
   input  wire mwpm_pkg::wheel_en_type               en,
   input  wire logic                                 polarity_inv,
   input  wire logic [mwpm_pkg::DEAD_W-1:0]          dead_band,
   input  wire logic signed [mwpm_pkg::SUM_W-1:0]    sum_in,
   output logic [mwpm_pkg::COMPARE_W-1:0]            compare,
   output logic                                      reverse
);

   logic signed [13:0]                          x;
   logic                                        neg;
   logic [11:0]                                 mag;
   logic [mwpm_pkg::WHEEL_RECIP_W+11:0]         prod;
   logic [13:0]                                 quo;
   logic signed [14:0]                          sq;
   logic signed [14:0]                          scaled_in;
   logic signed [14:0]                          scaled_ff;
   logic signed [15:0]                          p;
   logic signed [15:0]                          db;
   logic signed [15:0]                          pc;
   logic                                        nonneg;
   logic [mwpm_pkg::COMPARE_W-1:0]              m;
   logic [mwpm_pkg::COMPARE_W-1:0]              compare_in;
   logic                                        reverse_in;
   logic [mwpm_pkg::COMPARE_W-1:0]              compare_ff;
   logic                                        reverse_ff;

   // multiply stage
   assign x    = 14'(sum_in) + 14'(mwpm_pkg::AXIS_HALF);
   assign neg  = x[13];
   assign mag  = 12'(neg ? -x : x);
   assign prod = (mwpm_pkg::WHEEL_RECIP_W + 12)'(mag)
               * (mwpm_pkg::WHEEL_RECIP_W + 12)'(mwpm_pkg::WHEEL_RECIP);
   assign quo  = prod[mwpm_pkg::WHEEL_SHIFT+13:mwpm_pkg::WHEEL_SHIFT];
   assign sq   = $signed({1'b0, quo});
   assign scaled_in = neg ? -sq : sq;

   always_ff @(posedge clock) begin
      if (en.mul) begin
         scaled_ff <= scaled_in;
      end
   end

   // finish stage
   assign p  = 16'(scaled_ff) - 16'(mwpm_pkg::WHEEL_MAX);
   assign db = $signed({7'd0, dead_band});

   always_comb begin
      priority if ((p < db) && (p > -db)) begin
         pc = '0;
      end else if (p > 16'(mwpm_pkg::WHEEL_MAX)) begin
         pc = 16'(mwpm_pkg::WHEEL_MAX);
      end else if (p < -16'(mwpm_pkg::WHEEL_MAX)) begin
         pc = -16'(mwpm_pkg::WHEEL_MAX);
      end else begin
         pc = p;
      end
   end

   assign nonneg     = ~pc[15];
   assign m          = mwpm_pkg::COMPARE_W'(nonneg ? pc : -pc);
   assign compare_in = (nonneg ^ polarity_inv) ? m
                                               : mwpm_pkg::COMPARE_W'(mwpm_pkg::PWM_TOP) - m;
   assign reverse_in = ~(nonneg ^ polarity_inv);

   always_ff @(posedge clock) begin
      if (en.fin) begin
         compare_ff <= compare_in;
         reverse_ff <= reverse_in;
      end
   end

   assign compare = compare_ff;
   assign reverse = reverse_ff;

endmodule

`default_nettype wire

// ===== design/mecanum_wheel_pwm_mixer.sv =====
// mecanum wheel pwm mixer top level: pipeline control, config registers, mixing stage
// depends on mwpm_pkg, mwpm_median_batch, mwpm_axis_lane, mwpm_wheel_lane
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  four axes, two presence flags
//   rsp_      out         rsp_valid/rsp_stall  compare and reverse for four wheels
//   csr_      in          csr_valid/csr_ready  csr_index, csr_data
//
// one word in per cycle while req_stall is low
// app tilt mode gives one result for every fifth word, other modes one per word
// six stages: input, median, axis lanes, mixer, wheel multiply, wheel finish
// a stalled output holds only the stages behind it until a bubble is found
// synchronous reset clears valids and fill count and loads config reset values; csr_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_pwm_mixer (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_a,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_b,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_c,
   input  wire logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_d,
   input  wire logic                                    req_left_present,
   input  wire logic                                    req_right_present,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [mwpm_pkg::COMPARE_W-1:0]               rsp_compare_front_left,
   output logic                                         rsp_reverse_front_left,
   output logic [mwpm_pkg::COMPARE_W-1:0]               rsp_compare_front_right,
   output logic                                         rsp_reverse_front_right,
   output logic [mwpm_pkg::COMPARE_W-1:0]               rsp_compare_rear_right,
   output logic                                         rsp_reverse_rear_right,
   output logic [mwpm_pkg::COMPARE_W-1:0]               rsp_compare_rear_left,
   output logic                                         rsp_reverse_rear_left,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [mwpm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [mwpm_pkg::CSR_DATA_W-1:0]         csr_data
);

   mwpm_pkg::mode_type                       mode_ff;
   logic [mwpm_pkg::DEAD_W-1:0]              dead_band_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en_o;
   logic accept, tilt_wr, batch_last, v1_in;

   // stage 1
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]    s1_axis_ff [4];
   logic [1:0]                               s1_present_ff;
   mwpm_pkg::mode_type                       s1_mode_ff;
   // stage 2
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]    s2_axis_ff [4];
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]    s2_axis_in [4];
   logic [1:0]                               s2_present_ff;
   mwpm_pkg::mode_type                       s2_mode_ff;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]    pitch_med, roll_med;
   // stage 3
   logic signed [mwpm_pkg::AXIS_W-1:0]       s3_axis [4];
   mwpm_pkg::mode_type                       s3_mode_ff;
   // stage 4
   logic signed [mwpm_pkg::SUM_W-1:0]        s4_sum_ff [4];
   logic signed [mwpm_pkg::SUM_W-1:0]        s4_sum_in [4];
   logic signed [mwpm_pkg::SUM_W-1:0]        lx, ly, rx, ry;

   mwpm_pkg::wheel_en_type                   wheel_en;
   logic [mwpm_pkg::COMPARE_W-1:0]           wheel_compare [4];
   logic                                     wheel_reverse [4];
   logic                                     wheel_inv [4];

   // pipeline enables ripple back from the output register
   assign en_o = ~rsp_valid_ff | ~rsp_stall;
   assign en5  = ~v5_ff | en_o;
   assign en4  = ~v4_ff | en5;
   assign en3  = ~v3_ff | en4;
   assign en2  = ~v2_ff | en3;
   assign en1  = ~v1_ff | en2;

   assign req_stall = ~en1;
   assign accept    = req_valid & en1;
   assign tilt_wr   = accept & (mode_ff == mwpm_pkg::MODE_APP_TILT);
   assign v1_in     = accept & ((mode_ff != mwpm_pkg::MODE_APP_TILT) | batch_last);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mwpm_pkg::MODE_APP_JOY;
         dead_band_ff <= mwpm_pkg::DEAD_BAND_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mwpm_pkg::CSR_MIXING_MODE: begin
               mode_ff <= mwpm_pkg::mode_type'(csr_data[1:0]);
            end
            mwpm_pkg::CSR_DEAD_BAND: begin
               dead_band_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= v1_in;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en_o) begin
            rsp_valid_ff <= v5_ff;
         end
      end
   end

   // stage 1: input word
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_axis_ff[0] <= req_axis_a;
         s1_axis_ff[1] <= req_axis_b;
         s1_axis_ff[2] <= req_axis_c;
         s1_axis_ff[3] <= req_axis_d;
         s1_present_ff <= {req_right_present, req_left_present};
         s1_mode_ff    <= mode_ff;
      end
   end

   mwpm_median_batch u_median (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (tilt_wr),
      .pitch_in  (req_axis_a),
      .roll_in   (req_axis_b),
      .last      (batch_last),
      .pitch_med (pitch_med),
      .roll_med  (roll_med)
   );

   // stage 2: median select
   always_comb begin
      s2_axis_in[0] = s1_axis_ff[0];
      s2_axis_in[1] = s1_axis_ff[1];
      s2_axis_in[2] = s1_axis_ff[2];
      s2_axis_in[3] = s1_axis_ff[3];
      if (s1_mode_ff == mwpm_pkg::MODE_APP_TILT) begin
         s2_axis_in[0] = pitch_med;
         s2_axis_in[1] = roll_med;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_axis_ff    <= s2_axis_in;
         s2_present_ff <= s1_present_ff;
         s2_mode_ff    <= s1_mode_ff;
      end
   end

   // stage 3: axis lanes
   for (genvar i = 0; i < 4; i++) begin : g_axis
      mwpm_axis_lane u_axis (
         .clock   (clock),
         .en      (en3),
         .mode    (s2_mode_ff),
         .axis_in (s2_axis_ff[i]),
         .present (s2_present_ff[i/2]),
         .mapped  (s3_axis[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_mode_ff <= s2_mode_ff;
      end
   end

   // stage 4: mixing of lane results into wheel sums
   assign lx = mwpm_pkg::SUM_W'(s3_axis[0]);
   assign ly = mwpm_pkg::SUM_W'(s3_axis[1]);
   assign rx = mwpm_pkg::SUM_W'(s3_axis[2]);
   assign ry = mwpm_pkg::SUM_W'(s3_axis[3]);

   always_comb begin
      unique case (s3_mode_ff)
         mwpm_pkg::MODE_RADIO_JOY: begin
            s4_sum_in[0] = -ly - lx - ry - rx;
            s4_sum_in[1] = -ly + lx - ry + rx;
            s4_sum_in[2] = -ly - lx - ry + rx;
            s4_sum_in[3] = -ly + lx - ry - rx;
         end
         mwpm_pkg::MODE_APP_JOY: begin
            s4_sum_in[0] = -ly + lx - ry + rx;
            s4_sum_in[1] = -ly - lx - ry - rx;
            s4_sum_in[2] = -ly + lx - ry - rx;
            s4_sum_in[3] = -ly - lx - ry + rx;
         end
         mwpm_pkg::MODE_RADIO_TILT: begin
            s4_sum_in[0] = lx + ly;
            s4_sum_in[1] = lx - ly;
            s4_sum_in[2] = lx + ly;
            s4_sum_in[3] = lx - ly;
         end
         mwpm_pkg::MODE_APP_TILT: begin
            s4_sum_in[0] = -lx + ly;
            s4_sum_in[1] = -lx - ly;
            s4_sum_in[2] = -lx + ly;
            s4_sum_in[3] = -lx - ly;
         end
         default: begin
            s4_sum_in[0] = '0;
            s4_sum_in[1] = '0;
            s4_sum_in[2] = '0;
            s4_sum_in[3] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_sum_ff <= s4_sum_in;
      end
   end

   // stages 5 and 6: wheel lanes, front left and rear right inverted
   assign wheel_en.mul = en5;
   assign wheel_en.fin = en_o;
   assign wheel_inv[0] = 1'b1;
   assign wheel_inv[1] = 1'b0;
   assign wheel_inv[2] = 1'b1;
   assign wheel_inv[3] = 1'b0;

   for (genvar w = 0; w < 4; w++) begin : g_wheel
      mwpm_wheel_lane u_wheel (
         .clock        (clock),
         .en           (wheel_en),
         .polarity_inv (wheel_inv[w]),
         .dead_band    (dead_band_ff),
         .sum_in       (s4_sum_ff[w]),
         .compare      (wheel_compare[w]),
         .reverse      (wheel_reverse[w])
      );
   end

   assign rsp_compare_front_left  = wheel_compare[0];
   assign rsp_reverse_front_left  = wheel_reverse[0];
   assign rsp_compare_front_right = wheel_compare[1];
   assign rsp_reverse_front_right = wheel_reverse[1];
   assign rsp_compare_rear_right  = wheel_compare[2];
   assign rsp_reverse_rear_right  = wheel_reverse[2];
   assign rsp_compare_rear_left   = wheel_compare[3];
   assign rsp_reverse_rear_left   = wheel_reverse[3];

endmodule

`default_nettype wire

// ===== design/mwpm_checker.sv =====
// port level checks for the mecanum wheel pwm mixer, bound to the top level
// depends on mwpm_pkg and mecanum_wheel_pwm_mixer
`timescale 1ns / 1ps
`default_nettype none

module mwpm_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_stall,
   input wire logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_front_left,
   input wire logic                                    rsp_reverse_front_left,
   input wire logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_front_right,
   input wire logic                                    rsp_reverse_front_right,
   input wire logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_rear_right,
   input wire logic                                    rsp_reverse_rear_right,
   input wire logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_rear_left,
   input wire logic                                    rsp_reverse_rear_left
);

   // a stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_compare_front_left) && $stable(rsp_reverse_front_left)
         && $stable(rsp_compare_front_right) && $stable(rsp_reverse_front_right)
         && $stable(rsp_compare_rear_right) && $stable(rsp_reverse_rear_right)
         && $stable(rsp_compare_rear_left) && $stable(rsp_reverse_rear_left))
      else $error("result word changed while stalled");

   // no result is valid right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // inverted wheels always run between 1 and 500
   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_compare_front_left != 0 && rsp_compare_front_left <= 500
         && rsp_compare_rear_right != 0 && rsp_compare_rear_right <= 500)
      else $error("inverted wheel compare out of range");

   // plain wheels: compare at most 500, and a reversed wheel never shows a zero compare
   a_plain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_compare_front_right <= 500 && rsp_compare_rear_left <= 500
         && (!rsp_reverse_front_right || rsp_compare_front_right != 0)
         && (!rsp_reverse_rear_left || rsp_compare_rear_left != 0))
      else $error("plain wheel compare out of range");

endmodule

bind mecanum_wheel_pwm_mixer mwpm_checker u_mwpm_checker (.*);

`default_nettype wire

// ===== tb/sv/mecanum_wheel_pwm_mixer_test.sv =====
// self-checking test of the mecanum wheel pwm mixer: directed and random command words
// in all four mixing modes, predicted results checked field by field at the result port
// depends on mwpm_pkg and mecanum_wheel_pwm_mixer
`timescale 1ns / 1ps

module mecanum_wheel_pwm_mixer_test;

   typedef struct packed {
      logic signed [mwpm_pkg::AXIS_IN_W-1:0] axis_a;
      logic signed [mwpm_pkg::AXIS_IN_W-1:0] axis_b;
      logic signed [mwpm_pkg::AXIS_IN_W-1:0] axis_c;
      logic signed [mwpm_pkg::AXIS_IN_W-1:0] axis_d;
      logic                                  left_present;
      logic                                  right_present;
   } word_type;

   // wheel order: front left, front right, rear right, rear left
   typedef struct packed {
      logic [3:0][mwpm_pkg::COMPARE_W-1:0] compare;
      logic [3:0]                          reverse;
   } wheel_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_a = '0;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_b = '0;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_c = '0;
   logic signed [mwpm_pkg::AXIS_IN_W-1:0]   req_axis_d = '0;
   logic                                    req_left_present = 1'b0;
   logic                                    req_right_present = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_front_left;
   logic                                    rsp_reverse_front_left;
   logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_front_right;
   logic                                    rsp_reverse_front_right;
   logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_rear_right;
   logic                                    rsp_reverse_rear_right;
   logic [mwpm_pkg::COMPARE_W-1:0]          rsp_compare_rear_left;
   logic                                    rsp_reverse_rear_left;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [mwpm_pkg::CSR_IDX_W-1:0]          csr_index = '0;
   logic [mwpm_pkg::CSR_DATA_W-1:0]         csr_data = '0;

   mecanum_wheel_pwm_mixer DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_axis_a              (req_axis_a),
      .req_axis_b              (req_axis_b),
      .req_axis_c              (req_axis_c),
      .req_axis_d              (req_axis_d),
      .req_left_present        (req_left_present),
      .req_right_present       (req_right_present),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_compare_front_left  (rsp_compare_front_left),
      .rsp_reverse_front_left  (rsp_reverse_front_left),
      .rsp_compare_front_right (rsp_compare_front_right),
      .rsp_reverse_front_right (rsp_reverse_front_right),
      .rsp_compare_rear_right  (rsp_compare_rear_right),
      .rsp_reverse_rear_right  (rsp_reverse_rear_right),
      .rsp_compare_rear_left   (rsp_compare_rear_left),
      .rsp_reverse_rear_left   (rsp_reverse_rear_left),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   word_type         pending_words [$];
   wheel_result_type expected_results [$];
   word_type         shown_word;
   wheel_result_type want_result;
   int               words_sent = 0;
   int               words_taken = 0;
   int               error_count = 0;
   int               idle_pct = 17;

   // mixer state as the block should hold it
   mwpm_pkg::mode_type mix_mode = mwpm_pkg::MODE_APP_JOY;
   int                 dead_band = 20;
   int                 pitch_batch [mwpm_pkg::MEDIAN_WINDOW];
   int                 roll_batch [mwpm_pkg::MEDIAN_WINDOW];
   int                 batch_fill = 0;

   logic [3:0][mwpm_pkg::COMPARE_W-1:0] got_compare;
   logic [3:0]                          got_reverse;
   string                               wheel_name [4] = '{"front_left", "front_right",
                                                           "rear_right", "rear_left"};

   assign got_compare = {rsp_compare_rear_left, rsp_compare_rear_right,
                         rsp_compare_front_right, rsp_compare_front_left};
   assign got_reverse = {rsp_reverse_rear_left, rsp_reverse_rear_right,
                         rsp_reverse_front_right, rsp_reverse_front_left};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // truncating linear map onto -127..127
   function automatic int axis_map(input int v, input int lo, input int hi);
      return (v - lo) * 254 / (hi - lo) - 127;
   endfunction

   function automatic int batch_median(input bit roll_axis);
      int t [mwpm_pkg::MEDIAN_WINDOW];
      int k;
      for (int i = 0; i < mwpm_pkg::MEDIAN_WINDOW; i++) begin
         t[i] = roll_axis ? roll_batch[i] : pitch_batch[i];
      end
      for (int i = 0; i < mwpm_pkg::MEDIAN_WINDOW - 1; i++) begin
         for (int j = 0; j < mwpm_pkg::MEDIAN_WINDOW - 1 - i; j++) begin
            if (t[j] > t[j + 1]) begin
               k = t[j];
               t[j] = t[j + 1];
               t[j + 1] = k;
            end
         end
      end
      return t[mwpm_pkg::MEDIAN_WINDOW / 2];
   endfunction

   // returns {reverse, compare} for one wheel sum
   function automatic logic [mwpm_pkg::COMPARE_W:0] wheel_drive(input int s,
                                                               input bit inverted);
      int p;
      int m;
      logic [mwpm_pkg::COMPARE_W-1:0] cmp;
      logic rev;
      p = (s + 127) * 998 / 254 - 499;
      if (p < dead_band && p > -dead_band) p = 0;
      if (p > 499) p = 499;
      if (p < -499) p = -499;
      m = (p < 0) ? -p : p;
      if (inverted) begin
         cmp = mwpm_pkg::COMPARE_W'((p >= 0) ? 500 - m : m);
         rev = (p >= 0);
      end else begin
         cmp = mwpm_pkg::COMPARE_W'((p >= 0) ? m : 500 - m);
         rev = (p < 0);
      end
      return {rev, cmp};
   endfunction

   function automatic void predict_wheels(input word_type w);
      int a, b, c, d, lx, ly, rx, ry, p, q;
      int s [4];
      wheel_result_type r;
      a = int'($signed(w.axis_a));
      b = int'($signed(w.axis_b));
      c = int'($signed(w.axis_c));
      d = int'($signed(w.axis_d));
      if (mix_mode == mwpm_pkg::MODE_RADIO_JOY || mix_mode == mwpm_pkg::MODE_APP_JOY) begin
         if (!w.left_present) begin
            a = 50;
            b = 50;
         end
         if (!w.right_present) begin
            c = 50;
            d = 50;
         end
         lx = axis_map(a, 10, 90);
         ly = axis_map(b, 10, 90);
         rx = axis_map(c, 10, 90);
         ry = axis_map(d, 10, 90);
         if (mix_mode == mwpm_pkg::MODE_RADIO_JOY) begin
            s[0] = -ly - lx - ry - rx;
            s[1] = -ly + lx - ry + rx;
            s[2] = -ly - lx - ry + rx;
            s[3] = -ly + lx - ry - rx;
         end else begin
            s[0] = -ly + lx - ry + rx;
            s[1] = -ly - lx - ry - rx;
            s[2] = -ly + lx - ry - rx;
            s[3] = -ly - lx - ry + rx;
         end
      end else if (mix_mode == mwpm_pkg::MODE_RADIO_TILT) begin
         p = axis_map(a, 10, 90);
         q = axis_map(b, 10, 90);
         s[0] = p + q;
         s[1] = p - q;
         s[2] = p + q;
         s[3] = p - q;
      end else begin
         if (batch_fill >= mwpm_pkg::MEDIAN_WINDOW) batch_fill = 0;
         pitch_batch[batch_fill] = a;
         roll_batch[batch_fill] = b;
         batch_fill++;
         if (batch_fill < mwpm_pkg::MEDIAN_WINDOW) return;
         batch_fill = 0;
         p = axis_map(batch_median(1'b0), -90, 90);
         q = axis_map(batch_median(1'b1), -90, 90);
         s[0] = -p + q;
         s[1] = -p - q;
         s[2] = -p + q;
         s[3] = -p - q;
      end
      for (int i = 0; i < 4; i++) begin
         {r.reverse[i], r.compare[i]} = wheel_drive(s[i], (i == 0 || i == 2));
      end
      expected_results.push_back(r);
   endfunction

   function automatic logic signed [mwpm_pkg::AXIS_IN_W-1:0] random_axis(input int style);
      case (style)
         0: return mwpm_pkg::AXIS_IN_W'($urandom_range(90, 10));
         1: return mwpm_pkg::AXIS_IN_W'(int'($urandom_range(180)) - 90);
         default: return mwpm_pkg::AXIS_IN_W'($urandom);
      endcase
   endfunction

   function automatic word_type random_word();
      word_type w;
      int style;
      style = ($urandom_range(9) < 8) ? ((mix_mode >= mwpm_pkg::MODE_RADIO_TILT) ? 1 : 0)
                                      : 2;
      w.axis_a = random_axis(style);
      w.axis_b = random_axis(style);
      w.axis_c = random_axis(style);
      w.axis_d = random_axis(style);
      w.left_present = ($urandom_range(9) != 0);
      w.right_present = ($urandom_range(9) != 0);
      return w;
   endfunction

   task automatic queue_word(input int a, input int b, input int c, input int d,
                             input bit left_on, input bit right_on);
      word_type w;
      w.axis_a = mwpm_pkg::AXIS_IN_W'(a);
      w.axis_b = mwpm_pkg::AXIS_IN_W'(b);
      w.axis_c = mwpm_pkg::AXIS_IN_W'(c);
      w.axis_d = mwpm_pkg::AXIS_IN_W'(d);
      w.left_present = left_on;
      w.right_present = right_on;
      pending_words.push_back(w);
      words_sent++;
   endtask

   // called right after a rising edge; returns right after one
   task automatic write_reg(input logic [mwpm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mwpm_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == mwpm_pkg::CSR_MIXING_MODE) begin
         mix_mode = mwpm_pkg::mode_type'(value[1:0]);
      end else begin
         dead_band = int'(value);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input mwpm_pkg::mode_type m);
      write_reg(mwpm_pkg::CSR_MIXING_MODE, {7'($urandom), m});
   endtask

   task automatic settle();
      while (words_taken != words_sent) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_wheels(shown_word);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               shown_word = pending_words.pop_front();
               req_axis_a <= shown_word.axis_a;
               req_axis_b <= shown_word.axis_b;
               req_axis_c <= shown_word.axis_c;
               req_axis_d <= shown_word.axis_d;
               req_left_present <= shown_word.left_present;
               req_right_present <= shown_word.right_present;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               want_result = expected_results.pop_front();
               for (int w = 0; w < 4; w++) begin
                  if (got_compare[w] !== want_result.compare[w]) begin
                     $error("compare_%s: expected %0d, got %0d", wheel_name[w],
                            want_result.compare[w], got_compare[w]);
                     error_count++;
                  end
                  if (got_reverse[w] !== want_result.reverse[w]) begin
                     $error("reverse_%s: expected %0b, got %0b", wheel_name[w],
                            want_result.reverse[w], got_reverse[w]);
                     error_count++;
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   initial begin
      int count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // radio joystick, no deadband: extremes and absent sticks
      set_mode(mwpm_pkg::MODE_RADIO_JOY);
      write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd0);
      queue_word(-128, -128, -128, -128, 1, 1);
      queue_word(127, 127, 127, 127, 1, 1);
      queue_word(0, 0, 0, 0, 1, 1);
      queue_word(10, 90, 90, 10, 1, 1);
      queue_word(33, -7, 127, -128, 0, 1);
      queue_word(-128, 127, 5, 90, 1, 0);
      queue_word(1, 2, 3, 4, 0, 0);
      settle();

      // app joystick, default deadband
      set_mode(mwpm_pkg::MODE_APP_JOY);
      write_reg(mwpm_pkg::CSR_DEAD_BAND, mwpm_pkg::DEAD_BAND_RESET);
      queue_word(50, 50, 50, 50, 1, 1);
      queue_word(90, 10, 10, 90, 1, 1);
      queue_word(-128, 127, -128, 127, 1, 1);
      queue_word(52, 48, 49, 51, 1, 1);
      settle();

      // radio tilt, deadband 499; presence flags do not matter
      set_mode(mwpm_pkg::MODE_RADIO_TILT);
      write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd499);
      queue_word(127, -128, 0, 0, 0, 0);
      queue_word(90, 90, 77, -77, 1, 1);
      queue_word(-128, -128, 0, 0, 1, 0);
      settle();

      // app tilt: batch interrupted by another mode, then completed
      set_mode(mwpm_pkg::MODE_APP_TILT);
      write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd511);
      queue_word(-90, 90, 11, 22, 1, 1);
      queue_word(127, -128, -1, -2, 0, 0);
      queue_word(0, 0, 0, 0, 1, 0);
      settle();
      set_mode(mwpm_pkg::MODE_RADIO_TILT);
      queue_word(70, 20, 0, 0, 1, 1);
      settle();
      set_mode(mwpm_pkg::MODE_APP_TILT);
      write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd0);
      queue_word(-128, 127, 3, 3, 1, 1);
      queue_word(45, -45, 4, 4, 0, 1);
      settle();
      queue_word(5, 5, 0, 0, 1, 1);
      queue_word(5, -5, 0, 0, 1, 1);
      queue_word(-90, 90, 0, 0, 1, 1);
      queue_word(90, -90, 0, 0, 1, 1);
      queue_word(5, 5, 0, 0, 1, 1);
      settle();

      for (int phase = 0; phase < 13; phase++) begin
         set_mode(mwpm_pkg::mode_type'(phase % 4));
         case (phase % 5)
            0: write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd0);
            1: write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'd499);
            2: write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'($urandom_range(60)));
            3: write_reg(mwpm_pkg::CSR_DEAD_BAND, 9'($urandom_range(511)));
            default: write_reg(mwpm_pkg::CSR_DEAD_BAND, mwpm_pkg::DEAD_BAND_RESET);
         endcase
         idle_pct = (phase == 5) ? 0 : 17;
         count = (mix_mode == mwpm_pkg::MODE_APP_TILT) ? 130 : 90;
         for (int n = 0; n < count; n++) begin
            // in phase 2 the sender holds off halfway until the pipe has drained
            if (phase == 2 && n == count / 2) settle();
            pending_words.push_back(random_word());
            words_sent++;
         end
         settle();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mwpm_pkg.sv
design/mwpm_median_batch.sv
design/mwpm_axis_lane.sv
design/mwpm_wheel_lane.sv
design/mecanum_wheel_pwm_mixer.sv
design/mwpm_checker.sv
tb/sv/mecanum_wheel_pwm_mixer_test.sv
